// ----- hdl/clr_pkg.sv -----
`timescale 1ns / 1ps

package clr_pkg;

  // Fixed field widths of the configuration port and the result item.
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned COLOUR_W   = 8;

  // 1.16 slope fraction and its error accumulator.
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned ACC_W      = 18;
  localparam logic [ACC_W-1:0] SLOPE_ONE = ACC_W'(65536);

  // The divider produces one quotient bit per cycle.
  localparam int unsigned DIV_STEPS  = FRAC_W;
  localparam int unsigned DIV_CNT_W  = 5;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(200);
  localparam logic [CFG_W-1:0] PITCH_RESET  = CFG_W'(320);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH      = 2'd2;

  // Input item kinds carried in tuser.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [1:0] {
    MODE_VERT = 2'd0,
    MODE_HORZ = 2'd1,
    MODE_XMAJ = 2'd2,
    MODE_YMAJ = 2'd3
  } line_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_DIV   = 3'b100
  } ctrl_state_t;

endpackage

// ----- hdl/clr_div.sv -----
`timescale 1ns / 1ps

// Restoring divider: quotient = floor(65536 * minor / major) for minor <= major.
// One compare and subtract per cycle over the remainder, one quotient bit each.
module clr_div
  import clr_pkg::*;
#(
  parameter int unsigned DW = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DW-1:0]     minor,
  input  logic [DW-1:0]     major,
  output logic              done,
  output logic [FRAC_W-1:0] quotient
);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW:0]          rem_r, rem_nxt;
  logic [DW-1:0]        divisor_r, divisor_nxt;
  logic [FRAC_W-1:0]    q_r, q_nxt;
  logic [DW:0]          trial;
  logic                 fits;

  // The first step tests the integer part; every later step shifts in a zero.
  always_comb begin
    trial    = (cnt_r == '0) ? rem_r : {rem_r[DW-1:0], 1'b0};
    fits     = trial >= {1'b0, divisor_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    divisor_nxt = divisor_r;
    if (start) begin
      run_nxt     = 1'b1;
      cnt_nxt     = '0;
      rem_nxt     = {1'b0, minor};
      q_nxt       = '0;
      divisor_nxt = major;
    end else if (run_r) begin
      rem_nxt = fits ? (trial - {1'b0, divisor_r}) : trial;
      q_nxt   = {q_r[FRAC_W-2:0], fits};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    divisor_r <= divisor_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- hdl/clipped_line_rasterizer.sv -----
`timescale 1ns / 1ps
// Start item: taken into the setup state; a diagonal line then passes through the division
// state for the slope (17 divider steps) before the next item can be taken.
// Step item: one per cycle while a line runs and the output is not held; its pixel sits in
// the output register from the next cycle and a new item is taken as that pixel is taken.
// Reset is synchronous and active low: control state clears, registers return to
// 320 x 200 with a pitch of 320, and no line is active.
module clipped_line_rasterizer
  import clr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Fields from bit 0: start_x, start_y, end_x, end_y, colour_index.
  input  logic [((4*COORD_BITS+COLOUR_W+7)/8)*8-1:0] in_tdata,
  // Fields from bit 0: func.
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: pixel_x, pixel_y, pixel_address, pixel_colour.
  output logic [((2*COORD_BITS+ADDR_W+COLOUR_W+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0: write_pixel.
  output logic                   out_tuser,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned CW     = COORD_BITS + 1;
  localparam int unsigned CMP_W  = (CW > 16) ? CW : 16;
  localparam int unsigned OUT_RAW_W = 2 * COORD_BITS + ADDR_W + COLOUR_W;
  localparam int unsigned OUT_W  = ((OUT_RAW_W + 7) / 8) * 8;

  // Configuration registers.
  logic [CFG_W-1:0] width_r, height_r, pitch_r;

  // Line state.
  ctrl_state_t          state_r, state_nxt;
  logic                 active_r, active_nxt;
  line_mode_t           mode_r, mode_nxt;
  logic signed [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CW-1:0] stop_x_r, stop_x_nxt, stop_y_r, stop_y_nxt;
  logic                 xb_r, xb_nxt, yb_r, yb_nxt;
  logic [FRAC_W-1:0]    slope_r, slope_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic                 inside_r, inside_nxt;
  logic [COLOUR_W-1:0]  colour_r, colour_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 o_wr_r, o_wr_nxt, o_last_r, o_last_nxt;
  logic [CB-1:0]        o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic [ADDR_W-1:0]    o_addr_r, o_addr_nxt;
  logic [COLOUR_W-1:0]  o_col_r, o_col_nxt;

  // Input fields.
  logic signed [CB-1:0] f_sx, f_sy, f_ex, f_ey;
  logic [COLOUR_W-1:0]  f_col;
  logic signed [CW-1:0] a_sx, a_sy, a_ex, a_ey;
  logic                 a_xb, a_yb;

  logic                 accept;
  logic                 div_start, div_done;
  logic [FRAC_W-1:0]    div_q;
  logic signed [CW:0]   dxs, dys;
  logic [CW-1:0]        dx, dy;
  logic                 drop;
  logic signed [CW-1:0] x_step, y_step;
  logic [ACC_W-1:0]     acc_sum;
  logic                 carry;
  logic                 fin, wr;
  logic [ADDR_W-1:0]    addr;

  // Unsigned compare against a surface limit; a negative value is never at or past it.
  function automatic logic at_or_past(input logic signed [CW-1:0] v,
                                      input logic [CFG_W-1:0] lim);
    return !v[CW-1] && (CMP_W'(v[CW-2:0]) >= CMP_W'(lim));
  endfunction

  function automatic logic on_surface(input logic signed [CW-1:0] x,
                                      input logic signed [CW-1:0] y,
                                      input logic [CFG_W-1:0] w,
                                      input logic [CFG_W-1:0] h);
    return !x[CW-1] && !y[CW-1] && !at_or_past(x, w) && !at_or_past(y, h);
  endfunction

  assign f_sx  = $signed(in_tdata[CB-1:0]);
  assign f_sy  = $signed(in_tdata[2*CB-1:CB]);
  assign f_ex  = $signed(in_tdata[3*CB-1:2*CB]);
  assign f_ey  = $signed(in_tdata[4*CB-1:3*CB]);
  assign f_col = in_tdata[4*CB+COLOUR_W-1:4*CB];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Endpoint nudge applied as a start item is taken.
  always_comb begin
    a_sx = CW'(f_sx);
    a_sy = CW'(f_sy);
    a_ex = CW'(f_ex);
    a_ey = CW'(f_ey);
    a_xb = 1'b0;
    a_yb = 1'b0;
    if (f_sx == f_ex) begin
      a_sx = a_sx - CW'(1);
      a_ex = a_ex - CW'(1);
      if (f_sy > f_ey) begin
        a_yb = 1'b1;
        a_sy = a_sy - CW'(1);
      end
    end else begin
      if (f_sx > f_ex) begin
        a_sx = a_sx - CW'(1);
        a_xb = 1'b1;
      end else begin
        a_ex = a_ex - CW'(1);
      end
      if (f_sy > f_ey) begin
        a_yb = 1'b1;
        a_sy = a_sy - CW'(1);
        a_ey = a_ey - CW'(1);
      end
    end
  end

  // Setup cycle: distances, visibility and the off-surface test.
  always_comb begin
    dxs  = (CW+1)'(cur_x_r) - (CW+1)'(stop_x_r);
    dys  = (CW+1)'(cur_y_r) - (CW+1)'(stop_y_r);
    dx   = dxs[CW] ? CW'(-dxs) : CW'(dxs);
    dy   = dys[CW] ? CW'(-dys) : CW'(dys);
    drop = (at_or_past(cur_x_r, width_r) && at_or_past(stop_x_r, width_r)) ||
           (at_or_past(cur_y_r, height_r) && at_or_past(stop_y_r, height_r)) ||
           (cur_x_r[CW-1] && stop_x_r[CW-1]) ||
           (cur_y_r[CW-1] && stop_y_r[CW-1]);
  end

  // One DDA step from the present cursor.
  always_comb begin
    x_step  = xb_r ? (cur_x_r - CW'(1)) : (cur_x_r + CW'(1));
    y_step  = yb_r ? (cur_y_r - CW'(1)) : (cur_y_r + CW'(1));
    acc_sum = acc_r + ACC_W'(slope_r);
    carry   = acc_sum > SLOPE_ONE;
    wr      = (inside_r || on_surface(cur_x_r, cur_y_r, width_r, height_r)) &&
              !cur_x_r[CW-1] && !cur_y_r[CW-1];
    addr    = ADDR_W'($unsigned(cur_y_r)) * ADDR_W'(pitch_r) +
              ADDR_W'($unsigned(cur_x_r));
  end

  // Sequencer and stepping.
  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    mode_nxt   = mode_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    stop_x_nxt = stop_x_r;
    stop_y_nxt = stop_y_r;
    xb_nxt     = xb_r;
    yb_nxt     = yb_r;
    slope_nxt  = slope_r;
    acc_nxt    = acc_r;
    inside_nxt = inside_r;
    colour_nxt = colour_r;
    div_start  = 1'b0;
    fin        = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    o_wr_nxt   = o_wr_r;
    o_last_nxt = o_last_r;
    o_x_nxt    = o_x_r;
    o_y_nxt    = o_y_r;
    o_addr_nxt = o_addr_r;
    o_col_nxt  = o_col_r;

    case (state_r)
      ST_IDLE: begin
        if (accept && in_tuser == FUNC_START) begin
          active_nxt = 1'b0;
          cur_x_nxt  = a_sx;
          cur_y_nxt  = a_sy;
          stop_x_nxt = a_ex;
          stop_y_nxt = a_ey;
          xb_nxt     = a_xb;
          yb_nxt     = a_yb;
          colour_nxt = f_col;
          state_nxt  = ST_SETUP;
        end else if (accept && active_r) begin
          case (mode_r)
            MODE_VERT: begin
              cur_y_nxt = y_step;
              fin       = y_step == stop_y_r;
            end
            MODE_HORZ: begin
              cur_x_nxt = x_step;
              fin       = x_step == stop_x_r;
            end
            MODE_XMAJ: begin
              if (cur_x_r == stop_x_r) begin
                fin = 1'b1;
              end else begin
                cur_x_nxt = x_step;
                acc_nxt   = carry ? (acc_sum - SLOPE_ONE) : acc_sum;
                if (carry) begin
                  cur_y_nxt = y_step;
                end
              end
            end
            default: begin
              if (cur_y_r == stop_y_r) begin
                fin = 1'b1;
              end else begin
                cur_y_nxt = y_step;
                acc_nxt   = carry ? (acc_sum - SLOPE_ONE) : acc_sum;
                if (carry) begin
                  cur_x_nxt = x_step;
                end
              end
            end
          endcase
          active_nxt    = !fin;
          out_valid_nxt = 1'b1;
          o_wr_nxt      = wr;
          o_last_nxt    = fin;
          o_x_nxt       = cur_x_r[CB-1:0];
          o_y_nxt       = cur_y_r[CB-1:0];
          o_addr_nxt    = wr ? addr : '0;
          o_col_nxt     = colour_r;
        end
      end
      ST_SETUP: begin
        state_nxt  = ST_IDLE;
        inside_nxt = on_surface(cur_x_r, cur_y_r, width_r, height_r) &&
                     on_surface(stop_x_r, stop_y_r, width_r, height_r);
        acc_nxt    = '0;
        slope_nxt  = '0;
        if (!drop) begin
          if (cur_x_r == stop_x_r) begin
            mode_nxt   = MODE_VERT;
            active_nxt = cur_y_r != stop_y_r;
          end else if (cur_y_r == stop_y_r) begin
            mode_nxt   = MODE_HORZ;
            active_nxt = 1'b1;
          end else begin
            mode_nxt  = (dx >= dy) ? MODE_XMAJ : MODE_YMAJ;
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          slope_nxt  = div_q;
          active_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt  = ST_IDLE;
        active_nxt = 1'b0;
      end
    endcase
  end

  // Slope division: minor distance over major distance.
  clr_div #(
    .DW(CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .minor    ((dx >= dy) ? dy : dx),
    .major    ((dx >= dy) ? dx : dy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      pitch_r     <= PITCH_RESET;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SURFACE_WIDTH:  width_r  <= cfg_data;
          CFG_SURFACE_HEIGHT: height_r <= cfg_data;
          CFG_ROW_PITCH:      pitch_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Line and result data.
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    stop_x_r <= stop_x_nxt;
    stop_y_r <= stop_y_nxt;
    xb_r     <= xb_nxt;
    yb_r     <= yb_nxt;
    slope_r  <= slope_nxt;
    acc_r    <= acc_nxt;
    inside_r <= inside_nxt;
    colour_r <= colour_nxt;
    o_wr_r   <= o_wr_nxt;
    o_last_r <= o_last_nxt;
    o_x_r    <= o_x_nxt;
    o_y_r    <= o_y_nxt;
    o_addr_r <= o_addr_nxt;
    o_col_r  <= o_col_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_wr_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = OUT_W'({o_col_r, o_addr_r, o_y_r, o_x_r});

endmodule
